// ===== rtl/core/bloom_filter_fnv1a_double_hash_top_defines.svh =====
// Assertion macros used by the RTL that checks itself.
`ifndef BLOOM_FILTER_FNV1A_DOUBLE_HASH_TOP_DEFINES_SVH
`define BLOOM_FILTER_FNV1A_DOUBLE_HASH_TOP_DEFINES_SVH

`define BFH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bfh assertion failed");

`define BFH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bfh assertion failed");

`endif

// ===== rtl/core/bfh_pkg.sv =====
`default_nettype none
package bfh_pkg;
    localparam int unsigned FILTER_W = 21;
    localparam int unsigned K_W = 6;
    localparam int unsigned HASH_W = 32;
    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [8:0] FNV_PRIME_LOW = 9'h1b3;
    localparam int unsigned FNV_PRIME_SHIFT = 40;
    localparam logic [K_W-1:0] PROBE_CAP = 6'd32;
    localparam logic REG_NUM_HASHES = 1'b0;
    localparam logic REG_FILTER_BITS = 1'b1;
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    typedef struct packed {
        logic we;
        logic re;
        logic wdata;
    } store_ctl_t;

    function automatic logic [63:0] fnv_step(input logic [63:0] acc, input logic [7:0] b);
        logic [63:0] x;
        x = acc ^ {{56{b[7]}}, b};
        return (x << FNV_PRIME_SHIFT) + (x * {55'd0, FNV_PRIME_LOW});
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/bloom_filter_fnv1a_double_hash_top.sv =====
`default_nettype none
`include "bloom_filter_fnv1a_double_hash_top_defines.svh"
// Bloom filter keyed by a 64-bit FNV-1a style hash (each byte is sign-extended before the XOR)
// with double hashing. A key arrives one byte per transfer; bytes without last_byte are taken
// back to back. The last byte starts k probes, each of which runs a bit-serial remainder unit and
// then accesses the bit store (a write for an add, a read for a check), before the result is
// offered. After reset the bit store is cleared one bit per cycle until all MAX_BITS bits are
// clear, and no byte is taken meanwhile; the configuration port works throughout.
module bloom_filter_fnv1a_double_hash_top #(
    parameter longint unsigned MAX_BITS = 1048576
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_cmd,
    input  wire logic [7:0]  s_key_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_was_check,
    output logic             m_found
);
    import bfh_pkg::*;

    localparam int unsigned AW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_START  = 3'd2;
    localparam logic [2:0] S_MOD    = 3'd3;
    localparam logic [2:0] S_ACCESS = 3'd4;
    localparam logic [2:0] S_WAIT   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [K_W-1:0]      num_hashes_reg;
    logic [FILTER_W-1:0] filter_bits_reg;
    logic [63:0]         acc_reg, acc_next;
    logic [HASH_W-1:0]   h2_reg, h2_next;
    logic [HASH_W-1:0]   mix_reg, mix_next;
    logic [K_W-1:0]      cnt_reg, cnt_next;
    logic                check_reg, check_next;
    logic                all_set_reg, all_set_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_was_check_reg, m_was_check_next;
    logic                m_found_reg, m_found_next;
    logic [63:0]         hash_now;
    logic [K_W-1:0]      k_eff;
    logic [FILTER_W-1:0] m_eff;
    logic                cfg_wr;
    logic                in_xfer;
    logic                mod_start;
    logic                mod_done;
    logic [FILTER_W-1:0] mod_rem;
    store_ctl_t          store_ctl;
    logic [AW-1:0]       store_addr;
    logic                store_rd;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (paddr[2] == REG_FILTER_BITS) ? {11'd0, filter_bits_reg}
                                                   : {26'd0, num_hashes_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_hashes_reg  <= 6'd7;
            filter_bits_reg <= 21'h100000;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_NUM_HASHES:  num_hashes_reg  <= pwdata[K_W-1:0];
                REG_FILTER_BITS: filter_bits_reg <= pwdata[FILTER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        k_eff = (num_hashes_reg > PROBE_CAP) ? PROBE_CAP : num_hashes_reg;
        if (filter_bits_reg == '0) begin
            m_eff = FILTER_W'(1);
        end else if (64'(filter_bits_reg) > 64'(MAX_BITS)) begin
            m_eff = FILTER_W'(MAX_BITS);
        end else begin
            m_eff = filter_bits_reg;
        end
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign hash_now = fnv_step(acc_reg, s_key_byte);
    assign mod_start = (state_reg == S_START);

    always_comb begin
        state_next       = state_reg;
        acc_next         = acc_reg;
        h2_next          = h2_reg;
        mix_next         = mix_reg;
        cnt_next         = cnt_reg;
        check_next       = check_reg;
        all_set_next     = all_set_reg;
        clr_next         = clr_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_was_check_next = m_was_check_reg;
        m_found_next     = m_found_reg;
        store_ctl        = '{we: 1'b0, re: 1'b0, wdata: 1'b1};
        store_addr       = AW'(mod_rem);
        unique case (state_reg)
            S_CLEAR: begin
                store_ctl  = '{we: 1'b1, re: 1'b0, wdata: 1'b0};
                store_addr = clr_reg;
                clr_next   = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_BITS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    if (s_last_byte) begin
                        acc_next     = FNV_BASIS;
                        mix_next     = hash_now[HASH_W-1:0];
                        h2_next      = hash_now[63:HASH_W];
                        cnt_next     = k_eff;
                        check_next   = (s_cmd == CMD_CHECK);
                        all_set_next = 1'b1;
                        state_next   = (k_eff == '0) ? S_DONE : S_START;
                    end else begin
                        acc_next = hash_now;
                    end
                end
            end
            S_START: begin
                state_next = S_MOD;
            end
            S_MOD: begin
                if (mod_done) begin
                    state_next = S_ACCESS;
                end
            end
            S_ACCESS: begin
                store_ctl = '{we: !check_reg, re: check_reg, wdata: 1'b1};
                if (check_reg) begin
                    state_next = S_WAIT;
                end else begin
                    mix_next   = mix_reg + h2_reg;
                    cnt_next   = cnt_reg - K_W'(1);
                    state_next = (cnt_reg == K_W'(1)) ? S_DONE : S_START;
                end
            end
            S_WAIT: begin
                all_set_next = all_set_reg && store_rd;
                mix_next     = mix_reg + h2_reg;
                cnt_next     = cnt_reg - K_W'(1);
                state_next   = (cnt_reg == K_W'(1)) ? S_DONE : S_START;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_was_check_next = check_reg;
                    m_found_next     = check_reg && all_set_reg;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            acc_reg     <= FNV_BASIS;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        h2_reg          <= h2_next;
        mix_reg         <= mix_next;
        check_reg       <= check_next;
        all_set_reg     <= all_set_next;
        m_was_check_reg <= m_was_check_next;
        m_found_reg     <= m_found_next;
    end

    bfh_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (mix_reg),
        .modulus   (m_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    bfh_bit_store #(
        .DEPTH (MAX_BITS),
        .AW    (AW)
    ) u_store (
        .ctl_clk (aclk),
        .ctl     (store_ctl),
        .addr    (store_addr),
        .rd_data (store_rd)
    );

    assign m_valid     = m_valid_reg;
    assign m_was_check = m_was_check_reg;
    assign m_found     = m_found_reg;

    `BFH_ASSERT_IMP(a_clear_blocks_input, aclk, aresetn, state_reg == S_CLEAR, !s_ready)
    `BFH_ASSERT_IMP(a_add_not_found, aclk, aresetn, m_valid && !m_was_check, !m_found)
    `BFH_ASSERT_IMP(a_store_one_op, aclk, aresetn, store_ctl.we, !store_ctl.re)
    `BFH_ASSERT_IMP(a_mod_done_in_mod, aclk, aresetn, mod_done, state_reg == S_MOD)
    `BFH_ASSERT_NEXT(a_start_to_mod, aclk, aresetn, state_reg == S_START, state_reg == S_MOD)
endmodule
`default_nettype wire

// ===== rtl/core/bfh_mod_unit.sv =====
`default_nettype none
module bfh_mod_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [bfh_pkg::HASH_W-1:0]   dividend,
    input  wire logic [bfh_pkg::FILTER_W-1:0] modulus,
    output logic                              done,
    output logic [bfh_pkg::FILTER_W-1:0]      remainder
);
    import bfh_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [HASH_W-1:0]   dvd_reg, dvd_next;
    logic [FILTER_W-1:0] rem_reg, rem_next;
    logic [FILTER_W:0]   trial;

    // One quotient bit per cycle: shift in a dividend bit, subtract if it fits.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[HASH_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, modulus}) begin
                rem_next = FILTER_W'(trial - {1'b0, modulus});
            end else begin
                rem_next = FILTER_W'(trial);
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

// ===== rtl/core/bfh_bit_store.sv =====
`default_nettype none
module bfh_bit_store #(
    parameter longint unsigned DEPTH = 1048576,
    parameter int unsigned     AW    = 20
) (
    input  wire logic                ctl_clk,
    input  wire bfh_pkg::store_ctl_t ctl,
    input  wire logic [AW-1:0]       addr,
    output logic                     rd_data
);
    import bfh_pkg::*;

    logic mem [DEPTH];
    logic rd_data_reg;

    always_ff @(posedge ctl_clk) begin
        if (ctl.we) begin
            mem[addr] <= ctl.wdata;
        end
        if (ctl.re) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

// ===== bench/bloom_filter_fnv1a_double_hash_checker.sv =====
`default_nettype none
module bloom_filter_fnv1a_double_hash_checker #(
    parameter int unsigned STORE_BITS = 1048576
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_cmd,
    input  wire logic [7:0]  s_key_byte,
    input  wire logic        s_last_byte,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_was_check,
    input  wire logic        m_found,
    output int               fail_count,
    output int               pending_count
);
    import bfh_pkg::*;

    typedef struct packed {
        logic was_check;
        logic found;
    } verdict_t;

    logic [K_W-1:0] probes_reg;
    logic [FILTER_W-1:0] modulus_reg;
    logic [63:0] fnv_acc;
    bit filter_mem [STORE_BITS];
    verdict_t verdict_q[$];

    assign pending_count = verdict_q.size();

    function automatic logic [63:0] fold_byte(input logic [63:0] acc, input logic [7:0] b);
        logic [63:0] x;
        x = acc ^ {{56{b[7]}}, b};
        return x * 64'd1099511628211;
    endfunction

    task automatic finish_key(input logic [63:0] h, input logic is_check);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mix;
        int unsigned m;
        int unsigned k;
        int unsigned pos;
        logic hit;
        verdict_t v;
        lo = h[31:0];
        hi = h[63:32];
        m = (modulus_reg == 0) ? 1 : int'(modulus_reg);
        if (m > STORE_BITS) m = STORE_BITS;
        k = (probes_reg > PROBE_CAP) ? int'(PROBE_CAP) : int'(probes_reg);
        hit = 1'b1;
        for (int unsigned i = 0; i < k; i++) begin
            mix = lo + i[31:0] * hi;
            pos = mix % m;
            if (is_check) begin
                if (!filter_mem[pos]) hit = 1'b0;
            end else begin
                filter_mem[pos] = 1'b1;
            end
        end
        v.was_check = is_check;
        v.found = is_check && hit;
        verdict_q.push_back(v);
    endtask

    always @(posedge aclk) begin
        verdict_t e;
        int errs;
        errs = 0;
        if (!aresetn) begin
            probes_reg <= 6'd7;
            modulus_reg <= 21'd1048576 & 21'h1fffff;
            fnv_acc = FNV_BASIS;
            fail_count <= 0;
            verdict_q.delete();
            foreach (filter_mem[i]) filter_mem[i] = 1'b0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_NUM_HASHES) probes_reg <= pwdata[K_W-1:0];
                else modulus_reg <= pwdata[FILTER_W-1:0];
            end
            if (s_valid && s_ready) begin
                fnv_acc = fold_byte(fnv_acc, s_key_byte);
                if (s_last_byte) begin
                    finish_key(fnv_acc, s_cmd);
                    fnv_acc = FNV_BASIS;
                end
            end
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("unexpected result transfer");
                    errs++;
                end else begin
                    e = verdict_q.pop_front();
                    if (e.was_check !== m_was_check) begin
                        $error("was_check expected %0b actual %0b", e.was_check, m_was_check);
                        errs++;
                    end
                    if (e.found !== m_found) begin
                        $error("found expected %0b actual %0b", e.found, m_found);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end
endmodule
`default_nettype wire

// ===== bench/bloom_filter_fnv1a_double_hash_top_test.sv =====
`default_nettype none
module bloom_filter_fnv1a_double_hash_top_test;
    import bfh_pkg::*;

    localparam int unsigned STORE_BITS = 1048576;
    localparam int STALL_LIMIT = 4000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_cmd = 1'b0;
    logic [7:0] s_key_byte = 8'd0;
    logic s_last_byte = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_was_check;
    logic m_found;
    int fail_count;
    int pending_count;
    int idle_cycles = 0;
    byte unsigned key_pool [8][4];
    int key_len [8];

    always #5 aclk = ~aclk;

    bloom_filter_fnv1a_double_hash_top #(.MAX_BITS(STORE_BITS)) uut (.*);

    bloom_filter_fnv1a_double_hash_checker #(.STORE_BITS(STORE_BITS)) scoreboard (.*);

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** bloom_filter_fnv1a_double_hash_top: FAILED **");
            $finish;
        end
    end

    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 3) == 0) gap = 0;
            repeat (gap) @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
            m_ready <= 1'b0;
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_byte(input logic cmd, input logic [7:0] b, input logic last,
                             input bit burst);
        int gap;
        gap = burst ? 0 : int'($urandom_range(0, 11));
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_key_byte <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_key(input logic cmd, input int slot);
        bit burst;
        burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < key_len[slot]; i++)
            send_byte(cmd, key_pool[slot][i], i == key_len[slot] - 1, burst);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (1300) @(negedge aclk);
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        send_byte(CMD_CHECK, 8'h00, 1'b1, 1'b0);
        send_byte(CMD_ADD, 8'hff, 1'b0, 1'b0);
        send_byte(CMD_ADD, 8'h80, 1'b0, 1'b0);
        send_byte(CMD_ADD, 8'h01, 1'b1, 1'b0);
        send_byte(CMD_ADD, 8'hff, 1'b0, 1'b0);
        send_byte(CMD_ADD, 8'h80, 1'b0, 1'b0);
        send_byte(CMD_CHECK, 8'h01, 1'b1, 1'b0);
        send_byte(CMD_CHECK, 8'h7f, 1'b1, 1'b0);
        send_byte(CMD_ADD, 8'h55, 1'b0, 1'b0);
        send_byte(CMD_CHECK, 8'haa, 1'b1, 1'b0);
        drain();
        write_reg(REG_NUM_HASHES, 32'd0);
        write_reg(REG_FILTER_BITS, 32'd0);
        send_byte(CMD_CHECK, 8'h42, 1'b1, 1'b0);
        drain();
        write_reg(REG_NUM_HASHES, 32'd63);
        send_byte(CMD_ADD, 8'h11, 1'b1, 1'b0);
        send_byte(CMD_CHECK, 8'h22, 1'b1, 1'b0);
        drain();
        write_reg(REG_FILTER_BITS, 32'h001fffff);
        send_byte(CMD_CHECK, 8'h33, 1'b1, 1'b0);
        send_byte(CMD_ADD, 8'h33, 1'b1, 1'b0);
        send_byte(CMD_CHECK, 8'h33, 1'b1, 1'b0);
        drain();
        write_reg(REG_FILTER_BITS, 32'd8);
        write_reg(REG_NUM_HASHES, 32'd32);
        send_byte(CMD_CHECK, 8'hc3, 1'b1, 1'b0);
        drain();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_NUM_HASHES, 32'd3);
                    write_reg(REG_FILTER_BITS, 32'd64);
                end
                1: begin
                    write_reg(REG_NUM_HASHES, 32'd1);
                    write_reg(REG_FILTER_BITS, 32'd1000);
                end
                2: begin
                    write_reg(REG_NUM_HASHES, $urandom_range(0, 8));
                    write_reg(REG_FILTER_BITS, $urandom_range(8, 5000));
                end
                default: begin
                    write_reg(REG_NUM_HASHES, 32'd7);
                    write_reg(REG_FILTER_BITS, 32'd1048576);
                end
            endcase
            foreach (key_len[s]) begin
                key_len[s] = $urandom_range(1, 4);
                for (int j = 0; j < 4; j++) key_pool[s][j] = $urandom_range(0, 255);
            end
            for (int n = 0; n < 60; n++) begin
                if ($urandom_range(0, 9) == 0)
                    send_byte($urandom_range(0, 1), $urandom_range(0, 255), 1'b1, 1'b0);
                else
                    send_key($urandom_range(0, 1), $urandom_range(0, 7));
            end
            drain();
        end
        if (fail_count == 0) $display("** bloom_filter_fnv1a_double_hash_top: PASSED **");
        else $display("** bloom_filter_fnv1a_double_hash_top: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
